@@ design/lzeg_pkg.sv @@
// Shared types and constants for the LZ Elias-gamma decompressor.
// No dependencies; used by the interfaces, the top level and the checker.
package lzeg_pkg;

	// History window and length limits
	localparam int WINDOW_DEPTH = 4096;
	localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
	localparam int LENGTH_BITS  = 16;
	localparam int GAMMA_W      = LENGTH_BITS + 1;
	localparam int DIST_W       = 12;

	// Format constants
	localparam logic [7:0]        END_MARK    = 8'd255;
	localparam logic [DIST_W-1:0] LONG_BIAS   = DIST_W'(129);
	localparam logic [3:0]        TOP_OFS_BIT = 4'd10;

	// Commands
	localparam logic [1:0] CMD_BYTE  = 2'd0;
	localparam logic [1:0] CMD_CONT  = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	// Status codes
	localparam logic [1:0] WANTS_BYTE  = 2'd0;
	localparam logic [1:0] WANTS_CONT  = 2'd1;
	localparam logic [1:0] WANTS_DONE  = 2'd2;
	localparam logic [1:0] WANTS_ERROR = 2'd3;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] in_byte;
	} req_t;

	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_byte;
		logic [1:0] wants;
	} rsp_t;

endpackage

@@ design/lzeg_req_if.sv @@
// Request channel: command and compressed byte, valid/ready handshake.
// Depends on lzeg_pkg.
interface lzeg_req_if;
	logic             valid;
	logic             ready;
	lzeg_pkg::req_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ design/lzeg_rsp_if.sv @@
// Response channel: decoded byte and status, valid/ready handshake.
// Depends on lzeg_pkg.
interface lzeg_rsp_if;
	logic             valid;
	logic             ready;
	lzeg_pkg::rsp_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ design/lzeg_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lzeg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/lz_elias_gamma_decompressor_top.sv @@
// Top level of the LZ Elias-gamma (backwards LZ) stream decompressor.
// Depends on lzeg_pkg, lzeg_req_if, lzeg_rsp_if and lzeg_ram.
//
// Usage:
//  - req carries one item per command: supply a compressed byte, continue a
//    match copy, start a new stream, or no operation. Every accepted item
//    yields exactly one item on rsp: the decoded byte (if any) and the status
//    that tells the sender what to send next (byte, continue, done, error).
//  - One item is in work at a time. A byte item passes through decode, where
//    one flag/gamma/offset bit of the buffered byte is decoded per cycle (up
//    to 8), then posts its result. A continue item reads the history RAM
//    (registered read), writes the copied byte back, then posts the result;
//    a copy that ends also decodes buffered bits. Start and no-op items go
//    straight to posting the result.
//  - Results land in an output register; req is taken again as soon as the
//    result is registered, so a stalled receiver holds only the next result.
//  - Reset (arst_n low) clears the decoder and pointers and waits for the
//    first literal. The 4096-entry history RAM is not cleared: a match
//    distance is checked against the count of bytes produced, so only
//    written entries are ever read.
//  - Error (offset past produced data, oversized gamma) and finish are
//    sticky until a start item or reset.
module lz_elias_gamma_decompressor_top (
	input  logic              clk,
	input  logic              arst_n,
	lzeg_req_if.sink          req,
	lzeg_rsp_if.source        rsp
);

	localparam int AW = lzeg_pkg::ADDR_W;
	localparam int CW = lzeg_pkg::CNT_W;
	localparam int GW = lzeg_pkg::GAMMA_W;
	localparam int DW = lzeg_pkg::DIST_W;

	// Control sequencer
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DECODE = 2'd1;
	localparam logic [1:0] ST_CPRD   = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;

	// Decoder phase
	localparam logic [3:0] PH_FIRST   = 4'd0;
	localparam logic [3:0] PH_FLAG    = 4'd1;
	localparam logic [3:0] PH_LITERAL = 4'd2;
	localparam logic [3:0] PH_GSTOP   = 4'd3;
	localparam logic [3:0] PH_GDATA   = 4'd4;
	localparam logic [3:0] PH_OFFBYTE = 4'd5;
	localparam logic [3:0] PH_OFFBITS = 4'd6;
	localparam logic [3:0] PH_COPY    = 4'd7;
	localparam logic [3:0] PH_DONE    = 4'd8;
	localparam logic [3:0] PH_ERROR   = 4'd9;

	localparam logic [AW-1:0] WP_LAST = AW'(lzeg_pkg::WINDOW_DEPTH - 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(lzeg_pkg::WINDOW_DEPTH);
	localparam logic [AW:0]   DEPTH_X = (AW+1)'(lzeg_pkg::WINDOW_DEPTH);

	logic [1:0]    ctl_q, ctl_d;
	logic [3:0]    phase_q, phase_d;
	logic [AW-1:0] wp_q, wp_d;
	logic [CW-1:0] prod_q, prod_d;
	logic [7:0]    buf_q, buf_d;
	logic [3:0]    bits_q, bits_d;
	logic [GW-1:0] gamma_q, gamma_d;
	logic [GW-1:0] rem_q, rem_d;
	logic [DW-1:0] dist_q, dist_d;
	logic [1:0]    hib_q, hib_d;
	logic          res_vld_q, res_vld_d;
	logic [7:0]    res_byte_q, res_byte_d;
	logic          rsp_full_q;
	lzeg_pkg::rsp_t rsp_data_q;

	// Memory port signals
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;

	// Datapath temporaries
	logic          accept;
	logic          rsp_load;
	logic          bit_b;
	logic          bit_phase;
	logic [GW-1:0] gamma_sh;
	logic [GW-1:0] rem_dec;
	logic [DW-1:0] dist_short;
	logic [DW-1:0] dist_bit;
	logic [DW-1:0] dist_long;
	logic [3:0]    ofs_idx;
	logic [AW:0]   wp_x;
	logic [AW:0]   dist_x;
	logic [AW:0]   src_x;
	logic [1:0]    wants_now;

	assign req.ready = (ctl_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	assign rsp.valid = rsp_full_q;
	assign rsp.data  = rsp_data_q;

	// Copy source: write pointer minus distance, modulo the window depth
	assign wp_x      = {1'b0, wp_q};
	assign dist_x    = (AW+1)'(dist_q);
	assign src_x     = (wp_x >= dist_x) ? (wp_x - dist_x) : (wp_x + DEPTH_X - dist_x);
	assign mem_raddr = src_x[AW-1:0];

	// Bit decode helpers
	assign bit_b      = buf_q[7];
	assign bit_phase  = (phase_q == PH_FLAG) || (phase_q == PH_GSTOP) ||
	                    (phase_q == PH_GDATA) || (phase_q == PH_OFFBITS);
	assign gamma_sh   = {gamma_q[GW-2:0], bit_b};
	assign ofs_idx    = lzeg_pkg::TOP_OFS_BIT - {2'b00, hib_q};
	assign dist_short = DW'(req.data.in_byte) + DW'(1);
	assign dist_long  = dist_bit + lzeg_pkg::LONG_BIAS;
	assign rem_dec    = (rem_q != '0) ? (rem_q - GW'(1)) : rem_q;

	always_comb begin
		dist_bit          = dist_q;
		dist_bit[ofs_idx] = bit_b;
	end

	always_comb begin
		unique case (phase_q)
			PH_COPY:  wants_now = lzeg_pkg::WANTS_CONT;
			PH_DONE:  wants_now = lzeg_pkg::WANTS_DONE;
			PH_ERROR: wants_now = lzeg_pkg::WANTS_ERROR;
			default:  wants_now = lzeg_pkg::WANTS_BYTE;
		endcase
	end

	always_comb begin
		ctl_d      = ctl_q;
		phase_d    = phase_q;
		wp_d       = wp_q;
		prod_d     = prod_q;
		buf_d      = buf_q;
		bits_d     = bits_q;
		gamma_d    = gamma_q;
		rem_d      = rem_q;
		dist_d     = dist_q;
		hib_d      = hib_q;
		res_vld_d  = res_vld_q;
		res_byte_d = res_byte_q;
		mem_we     = 1'b0;
		mem_waddr  = wp_q;
		mem_wdata  = req.data.in_byte;
		mem_re     = 1'b0;
		rsp_load   = 1'b0;

		unique case (ctl_q)
			ST_IDLE: begin
				if (accept) begin
					res_vld_d  = 1'b0;
					res_byte_d = 8'd0;
					unique case (req.data.cmd)
						lzeg_pkg::CMD_START: begin
							wp_d    = '0;
							prod_d  = '0;
							buf_d   = 8'd0;
							bits_d  = 4'd0;
							phase_d = PH_FIRST;
							gamma_d = GW'(1);
							rem_d   = '0;
							dist_d  = '0;
							hib_d   = 2'd0;
							ctl_d   = ST_EMIT;
						end
						lzeg_pkg::CMD_BYTE: begin
							ctl_d = ST_DECODE;
							unique case (phase_q) inside
								PH_FIRST, PH_LITERAL: begin
									mem_we     = 1'b1;
									wp_d       = (wp_q == WP_LAST) ? '0 : wp_q + AW'(1);
									prod_d     = (prod_q == CNT_MAX) ? prod_q : prod_q + CW'(1);
									res_vld_d  = 1'b1;
									res_byte_d = req.data.in_byte;
									phase_d    = PH_FLAG;
								end
								PH_OFFBYTE: begin
									hib_d = 2'd0;
									if (!req.data.in_byte[7]) begin
										dist_d = dist_short;
										if (CW'(dist_short) > prod_q || dist_short == '0) begin
											phase_d = PH_ERROR;
										end else begin
											phase_d = PH_COPY;
										end
									end else begin
										dist_d  = DW'(req.data.in_byte[6:0]);
										phase_d = PH_OFFBITS;
									end
								end
								PH_FLAG, PH_GSTOP, PH_GDATA, PH_OFFBITS: begin
									if (bits_q == 4'd0) begin
										buf_d  = req.data.in_byte;
										bits_d = 4'd8;
									end
								end
								default: begin
								end
							endcase
						end
						lzeg_pkg::CMD_CONT: begin
							if (phase_q == PH_COPY) begin
								mem_re = 1'b1;
								ctl_d  = ST_CPRD;
							end else begin
								ctl_d = ST_EMIT;
							end
						end
						default: begin
							ctl_d = ST_EMIT;
						end
					endcase
				end
			end

			// One buffered bit per cycle until a byte or a copy is needed, or on finish or error
			ST_DECODE: begin
				if (bit_phase && bits_q != 4'd0) begin
					buf_d  = {buf_q[6:0], 1'b0};
					bits_d = bits_q - 4'd1;
					unique case (phase_q)
						PH_FLAG: begin
							if (!bit_b) begin
								phase_d = PH_LITERAL;
							end else begin
								gamma_d = GW'(1);
								phase_d = PH_GSTOP;
							end
						end
						PH_GSTOP: begin
							if (!bit_b) begin
								phase_d = PH_GDATA;
							end else if (gamma_q[7:0] == lzeg_pkg::END_MARK) begin
								phase_d = PH_DONE;
							end else begin
								rem_d   = gamma_q + GW'(1);
								phase_d = PH_OFFBYTE;
							end
						end
						PH_GDATA: begin
							gamma_d = gamma_sh;
							phase_d = gamma_sh[GW-1] ? PH_ERROR : PH_GSTOP;
						end
						default: begin
							// high offset bits, 10 down to 7
							if (hib_q == 2'd3) begin
								hib_d  = 2'd0;
								dist_d = dist_long;
								if (CW'(dist_long) > prod_q || dist_long == '0) begin
									phase_d = PH_ERROR;
								end else begin
									phase_d = PH_COPY;
								end
							end else begin
								dist_d = dist_bit;
								hib_d  = hib_q + 2'd1;
							end
						end
					endcase
				end else begin
					ctl_d = ST_EMIT;
				end
			end

			// History read data is here: write it back at the head
			ST_CPRD: begin
				mem_we     = 1'b1;
				mem_wdata  = mem_rdata;
				res_vld_d  = 1'b1;
				res_byte_d = mem_rdata;
				wp_d       = (wp_q == WP_LAST) ? '0 : wp_q + AW'(1);
				prod_d     = (prod_q == CNT_MAX) ? prod_q : prod_q + CW'(1);
				rem_d      = rem_dec;
				if (rem_dec == '0) begin
					phase_d = PH_FLAG;
					ctl_d   = ST_DECODE;
				end else begin
					ctl_d = ST_EMIT;
				end
			end

			default: begin
				if (!rsp_full_q || rsp.ready) begin
					rsp_load = 1'b1;
					ctl_d    = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q      <= ST_IDLE;
			phase_q    <= PH_FIRST;
			wp_q       <= '0;
			prod_q     <= '0;
			buf_q      <= 8'd0;
			bits_q     <= 4'd0;
			gamma_q    <= GW'(1);
			rem_q      <= '0;
			dist_q     <= '0;
			hib_q      <= 2'd0;
			rsp_full_q <= 1'b0;
		end else begin
			ctl_q   <= ctl_d;
			phase_q <= phase_d;
			wp_q    <= wp_d;
			prod_q  <= prod_d;
			buf_q   <= buf_d;
			bits_q  <= bits_d;
			gamma_q <= gamma_d;
			rem_q   <= rem_d;
			dist_q  <= dist_d;
			hib_q   <= hib_d;
			if (rsp_load) begin
				rsp_full_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_full_q <= 1'b0;
			end
		end
	end

	// Result payload, no reset needed
	always_ff @(posedge clk) begin
		res_vld_q  <= res_vld_d;
		res_byte_q <= res_byte_d;
		if (rsp_load) begin
			rsp_data_q.out_valid <= res_vld_q;
			rsp_data_q.out_byte  <= res_byte_q;
			rsp_data_q.wants     <= wants_now;
		end
	end

	lzeg_ram #(
		.WIDTH (8),
		.DEPTH (lzeg_pkg::WINDOW_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

@@ design/lzeg_checker.sv @@
// Port-level checks for the decompressor top, attached by bind.
// Depends on lzeg_pkg and lz_elias_gamma_decompressor_top.
module lzeg_port_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input lzeg_pkg::rsp_t rsp_data
);

	// A held result does not change while the receiver stalls
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// No byte means a zero byte field
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.out_valid |-> rsp_data.out_byte == 8'd0)
		else $error("out_byte nonzero without a byte");

	// One item in work: request side closes right after a take
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second item taken while one is in work");

	// A continue is never asked for right after a finish was handed over
	a_cont_byte: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.wants == lzeg_pkg::WANTS_CONT && $past(rsp_valid) &&
		$past(rsp_ready) && $past(rsp_data.wants) == lzeg_pkg::WANTS_DONE |-> 1'b0)
		else $error("copy requested right after finish");

endmodule

bind lz_elias_gamma_decompressor_top lzeg_port_checker u_lzeg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

@@ sim/lzeg_checker.sv @@
`timescale 1ns / 100ps
// Response checker for the LZ Elias-gamma decompressor: decodes every accepted
// request on its own and compares each response item against that prediction.
// Depends on lzeg_pkg, lzeg_req_if and lzeg_rsp_if.
module lzeg_checker (
	input  logic clk,
	input  logic arst_n,
	lzeg_req_if  req,
	lzeg_rsp_if  rsp,
	output int   errors,
	output int   outstanding
);

	typedef enum logic [3:0] {
		ST_FIRST, ST_FLAG, ST_LITERAL, ST_GSTOP, ST_GDATA,
		ST_OFFBYTE, ST_OFFBITS, ST_COPY, ST_DONE, ST_ERROR
	} dec_phase_t;

	logic [7:0]                   hist [0:lzeg_pkg::WINDOW_DEPTH-1];
	logic [lzeg_pkg::ADDR_W-1:0]  wr_ptr;
	logic [lzeg_pkg::CNT_W-1:0]   produced;
	logic [7:0]                   bitbuf;
	logic [3:0]                   nbits;
	dec_phase_t                   ph;
	logic [lzeg_pkg::GAMMA_W-1:0] gamma;
	logic [lzeg_pkg::GAMMA_W-1:0] copy_left;
	logic [lzeg_pkg::DIST_W-1:0]  match_dist;
	logic [1:0]                   hi_seen;

	lzeg_pkg::rsp_t predicted_rsp_q[$];

	task automatic clear_decoder();
		wr_ptr     = '0;
		produced   = '0;
		bitbuf     = '0;
		nbits      = '0;
		ph         = ST_FIRST;
		gamma      = lzeg_pkg::GAMMA_W'(1);
		copy_left  = '0;
		match_dist = '0;
		hi_seen    = '0;
	endtask

	task automatic append_history(input logic [7:0] b);
		hist[wr_ptr] = b;
		wr_ptr = (wr_ptr == lzeg_pkg::ADDR_W'(lzeg_pkg::WINDOW_DEPTH - 1)) ? '0 :
			wr_ptr + lzeg_pkg::ADDR_W'(1);
		if (produced < lzeg_pkg::CNT_W'(lzeg_pkg::WINDOW_DEPTH))
			produced = produced + lzeg_pkg::CNT_W'(1);
	endtask

	task automatic check_distance();
		ph = (lzeg_pkg::CNT_W'(match_dist) > produced || match_dist == '0) ?
			ST_ERROR : ST_COPY;
	endtask

	// consume buffered bits until a byte, a continue or an end is needed
	task automatic drain_bits();
		logic b;
		while ((ph == ST_FLAG || ph == ST_GSTOP || ph == ST_GDATA || ph == ST_OFFBITS)
				&& nbits != '0) begin
			b      = bitbuf[7];
			bitbuf = {bitbuf[6:0], 1'b0};
			nbits  = nbits - 4'd1;
			case (ph)
			ST_FLAG: begin
				if (!b) begin
					ph = ST_LITERAL;
				end else begin
					gamma = lzeg_pkg::GAMMA_W'(1);
					ph    = ST_GSTOP;
				end
			end
			ST_GSTOP: begin
				if (!b) begin
					ph = ST_GDATA;
				end else if (gamma[7:0] == lzeg_pkg::END_MARK) begin
					ph = ST_DONE;
				end else begin
					copy_left = gamma + lzeg_pkg::GAMMA_W'(1);
					ph        = ST_OFFBYTE;
				end
			end
			ST_GDATA: begin
				gamma = {gamma[lzeg_pkg::GAMMA_W-2:0], b};
				ph    = gamma[lzeg_pkg::LENGTH_BITS] ? ST_ERROR : ST_GSTOP;
			end
			default: begin
				// high offset bits arrive MSB first: bits 10 down to 7
				match_dist = match_dist + (lzeg_pkg::DIST_W'(b) <<
					(lzeg_pkg::TOP_OFS_BIT - 4'(hi_seen)));
				if (hi_seen == 2'd3) begin
					hi_seen    = '0;
					match_dist = match_dist + lzeg_pkg::LONG_BIAS;
					check_distance();
				end else begin
					hi_seen = hi_seen + 2'd1;
				end
			end
			endcase
		end
	endtask

	task automatic decode_item(input lzeg_pkg::req_t it, output lzeg_pkg::rsp_t res);
		int src;
		res = '0;
		case (it.cmd)
		lzeg_pkg::CMD_START: clear_decoder();
		lzeg_pkg::CMD_BYTE: begin
			case (ph) inside
			ST_FIRST, ST_LITERAL: begin
				append_history(it.in_byte);
				res.out_valid = 1'b1;
				res.out_byte  = it.in_byte;
				ph            = ST_FLAG;
			end
			ST_OFFBYTE: begin
				hi_seen = '0;
				if (!it.in_byte[7]) begin
					match_dist = lzeg_pkg::DIST_W'(it.in_byte) + lzeg_pkg::DIST_W'(1);
					check_distance();
				end else begin
					match_dist = lzeg_pkg::DIST_W'(it.in_byte[6:0]);
					ph         = ST_OFFBITS;
				end
			end
			ST_FLAG, ST_GSTOP, ST_GDATA, ST_OFFBITS: begin
				if (nbits == '0) begin
					bitbuf = it.in_byte;
					nbits  = 4'd8;
				end
			end
			default: ;
			endcase
			drain_bits();
		end
		lzeg_pkg::CMD_CONT: begin
			if (ph == ST_COPY) begin
				src = int'(wr_ptr) - int'(match_dist);
				if (src < 0)
					src += lzeg_pkg::WINDOW_DEPTH;
				res.out_valid = 1'b1;
				res.out_byte  = hist[src];
				append_history(res.out_byte);
				if (copy_left != '0)
					copy_left = copy_left - lzeg_pkg::GAMMA_W'(1);
				if (copy_left == '0) begin
					ph = ST_FLAG;
					drain_bits();
				end
			end
		end
		default: ;
		endcase
		case (ph)
		ST_COPY:  res.wants = lzeg_pkg::WANTS_CONT;
		ST_DONE:  res.wants = lzeg_pkg::WANTS_DONE;
		ST_ERROR: res.wants = lzeg_pkg::WANTS_ERROR;
		default:  res.wants = lzeg_pkg::WANTS_BYTE;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		lzeg_pkg::rsp_t want;
		lzeg_pkg::rsp_t got;
		if (!arst_n) begin
			clear_decoder();
			predicted_rsp_q.delete();
			errors      = 0;
			outstanding = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = rsp.data;
				if (predicted_rsp_q.size() == 0) begin
					errors++;
					$error("response item with none predicted: out_byte %0h, wants %0d",
						got.out_byte, got.wants);
				end else begin
					want = predicted_rsp_q.pop_front();
					if (got.out_valid !== want.out_valid) begin
						errors++;
						$error("out_valid: expected %0d, actual %0d", want.out_valid, got.out_valid);
					end
					if (got.out_byte !== want.out_byte) begin
						errors++;
						$error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
					end
					if (got.wants !== want.wants) begin
						errors++;
						$error("wants: expected %0d, actual %0d", want.wants, got.wants);
					end
				end
			end
			if (req.valid && req.ready) begin
				decode_item(req.data, want);
				predicted_rsp_q.push_back(want);
			end
			outstanding = predicted_rsp_q.size();
		end
	end

endmodule

@@ sim/lz_elias_gamma_decompressor_top_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for lz_elias_gamma_decompressor_top: encodes random compressed
// streams, drives them with random idling and gives the verdict.
// Depends on lzeg_pkg, both channel interfaces, the block and lzeg_checker.
module lz_elias_gamma_decompressor_top_tb;

	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 12;
	localparam int RANDOM_ITEMS = 1950;
	localparam int TAIL_ITEMS   = 250;        // last stretch runs with no idling
	localparam int LONG_HOLD    = 300;        // receiver stall that backs up the input
	localparam int DRAIN_CYCLES = 30;
	localparam int TIMEOUT_NS   = 10_000_000;
	// farthest distance the offset format can express: 127 + (15 << 7) + 129
	localparam int FAR_DIST     = 2176;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	lzeg_req_if req_ch ();
	lzeg_rsp_if rsp_ch ();

	int fail_count;
	int pending_count;

	bit idle_en      = 1'b1;   // random gaps on both sides
	bit hold_request = 1'b0;   // asks the receiver for one long stall

	// stream under construction, in the order the decoder consumes it
	lzeg_pkg::req_t stream_q[$];
	int   flag_slot;           // index of the byte that holds the current flag bits
	int   flag_bits_free;      // flag bits still unused in that byte
	int   bytes_out;           // decompressed bytes the stream has produced so far
	int   items_sent;

	lz_elias_gamma_decompressor_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	lzeg_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.errors      (fail_count),
		.outstanding (pending_count)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("DONE: errors detected");
		$finish;
	end

	// Receiver: short random stalls, or one long stall on request. The long one is
	// counted here so the sender keeps offering items while the block backs up.
	initial begin
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	function automatic lzeg_pkg::req_t make_item(input logic [1:0] cmd, input logic [7:0] b);
		lzeg_pkg::req_t t;
		t.cmd     = cmd;
		t.in_byte = b;
		return t;
	endfunction

	// Offer one item and return at the edge that takes it. Valid stays high
	// unless a gap is inserted, so back-to-back items need no extra edge.
	task automatic send_item(input lzeg_pkg::req_t it);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= it;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		if (it.cmd != lzeg_pkg::CMD_NOP)
			items_sent++;
	endtask

	// Sender goes quiet until every predicted response has come back.
	task automatic drain_pause();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending_count == 0);
		@(posedge clk);
	endtask

	// Send the built stream; noise_pct sprinkles random items in (stray bytes,
	// stray continues, no-ops, restarts), which breaks the stream on purpose.
	task automatic send_stream(input int noise_pct);
		foreach (stream_q[i]) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_item(make_item(2'($urandom_range(0, 3)), 8'($urandom)));
			send_item(stream_q[i]);
		end
		stream_q.delete();
	endtask

	// ---- stream encoder ----

	task automatic begin_stream(input bit with_start);
		if (with_start)
			stream_q.push_back(make_item(lzeg_pkg::CMD_START, 8'($urandom)));
		flag_bits_free = 0;
		bytes_out      = 0;
	endtask

	// A flag byte is placed where the decoder first runs out of bits, then
	// filled MSB first; spare bits stay random.
	task automatic put_flag_bit(input logic b);
		lzeg_pkg::req_t t;
		if (flag_bits_free == 0) begin
			stream_q.push_back(make_item(lzeg_pkg::CMD_BYTE, 8'($urandom)));
			flag_slot      = stream_q.size() - 1;
			flag_bits_free = 8;
		end
		t = stream_q[flag_slot];
		t.in_byte[flag_bits_free - 1] = b;
		stream_q[flag_slot] = t;
		flag_bits_free--;
	endtask

	task automatic add_literal(input bit first, input logic [7:0] b);
		if (!first)
			put_flag_bit(1'b0);
		stream_q.push_back(make_item(lzeg_pkg::CMD_BYTE, b));
		bytes_out++;
	endtask

	// interleaved gamma: for each bit under the leading one a 0 then the bit, then a 1
	task automatic add_gamma(input int v);
		int msb;
		msb = 0;
		while ((v >> (msb + 1)) != 0)
			msb++;
		for (int i = msb - 1; i >= 0; i--) begin
			put_flag_bit(1'b0);
			put_flag_bit(v[i]);
		end
		put_flag_bit(1'b1);
	endtask

	// Match of v + 1 bytes from d back. Short form for d up to 128; otherwise
	// the byte holds the low 7 bits of d - 129 and four flag bits give bits 10..7.
	// A distance past the produced data leads to error, so no continues follow.
	task automatic add_match(input int v, input int d);
		int x;
		put_flag_bit(1'b1);
		add_gamma(v);
		if (d <= 128) begin
			stream_q.push_back(make_item(lzeg_pkg::CMD_BYTE, 8'(d - 1)));
		end else begin
			x = d - 129;
			stream_q.push_back(make_item(lzeg_pkg::CMD_BYTE, 8'h80 | 8'(x & 127)));
			for (int i = 10; i >= 7; i--)
				put_flag_bit(x[i]);
		end
		if (d <= bytes_out) begin
			repeat (v + 1)
				stream_q.push_back(make_item(lzeg_pkg::CMD_CONT, 8'($urandom)));
			bytes_out += v + 1;
		end
	endtask

	// end marker: any gamma value whose low byte is 255
	task automatic add_end();
		put_flag_bit(1'b1);
		add_gamma($urandom_range(0, 1) ? (($urandom_range(1, 255) << 8) | 255) : 255);
	endtask

	// gamma value one bit too wide: error on its last data bit
	task automatic add_long_gamma();
		put_flag_bit(1'b1);
		add_gamma((1 << lzeg_pkg::LENGTH_BITS) |
			$urandom_range(0, (1 << lzeg_pkg::LENGTH_BITS) - 1));
	endtask

	// mostly short copies, a few long ones; never a low byte that reads as the end
	function automatic int pick_length();
		int v;
		do begin
			case ($urandom_range(0, 19)) inside
			0:          v = $urandom_range(65, 700);
			1, 2, 3, 4: v = $urandom_range(7, 64);
			default:    v = $urandom_range(1, 6);
			endcase
		end while (v[7:0] == lzeg_pkg::END_MARK);
		return v;
	endfunction

	// distance within reach; covers near, full reach, the short/long form boundary
	function automatic int pick_distance(input int lim);
		case ($urandom_range(0, 9)) inside
		0, 1, 2, 3: return $urandom_range(1, (lim < 8) ? lim : 8);
		4, 5, 6:    return $urandom_range(1, lim);
		7:          return lim;
		8:          return (lim >= 129) ? $urandom_range(128, 129) : lim;
		default:    return (lim >= 130) ? $urandom_range(130, lim) : $urandom_range(1, lim);
		endcase
	endfunction

	// Well-formed stream with random content; a few end in an error or are cut
	// short (left without end marker, cleared by the next start).
	task automatic random_stream();
		int lim;
		int steps;
		int r;
		begin_stream(1'b1);
		add_literal(1'b1, 8'($urandom));
		steps = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 40);
		for (int k = 0; k < steps; k++) begin
			lim = (bytes_out < FAR_DIST) ? bytes_out : FAR_DIST;
			r   = $urandom_range(0, 99);
			if (r < 45) begin
				add_literal(1'b0, 8'($urandom));
			end else if (r < 96) begin
				add_match(pick_length(), pick_distance(lim));
			end else if (r < 98) begin
				if (lim < FAR_DIST) begin
					add_match(pick_length(), $urandom_range(lim + 1, FAR_DIST));
					return;
				end
				add_match(pick_length(), pick_distance(lim));
			end else begin
				add_long_gamma();
				return;
			end
		end
		if ($urandom_range(0, 9) != 0)
			add_end();
	endtask

	initial begin
		int stream_no;

		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: no-op and a stray continue before anything; first stream
		// straight after reset with both extreme literals, a short copy and an
		// out-of-reach long offset, then items sent while in error. Then an end
		// marker with items after finish, and a gamma value that is too wide.
		stream_q.push_back(make_item(lzeg_pkg::CMD_NOP, 8'hFF));
		stream_q.push_back(make_item(lzeg_pkg::CMD_CONT, 8'h00));
		begin_stream(1'b0);
		add_literal(1'b1, 8'h00);
		add_literal(1'b0, 8'hFF);
		add_match(1, 2);
		add_match(1, FAR_DIST);
		stream_q.push_back(make_item(lzeg_pkg::CMD_BYTE, 8'h80));
		stream_q.push_back(make_item(lzeg_pkg::CMD_CONT, 8'h7F));
		begin_stream(1'b1);
		add_literal(1'b1, 8'h7F);
		add_end();
		stream_q.push_back(make_item(lzeg_pkg::CMD_BYTE, 8'h55));
		stream_q.push_back(make_item(lzeg_pkg::CMD_CONT, 8'hAA));
		stream_q.push_back(make_item(lzeg_pkg::CMD_NOP, 8'h00));
		begin_stream(1'b1);
		add_literal(1'b1, 8'h5A);
		add_long_gamma();
		send_stream(0);
		drain_pause();

		// Random streams; idling is switched per stream and off in the tail.
		items_sent = 0;
		stream_no  = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent > RANDOM_ITEMS - TAIL_ITEMS)
				idle_en = 1'b0;
			else
				idle_en = ($urandom_range(0, 4) != 0);
			if (stream_no == 0)
				hold_request = 1'b1;
			if (stream_no % 15 == 14)
				drain_pause();
			random_stream();
			send_stream(2);
			stream_no++;
		end

		req_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending_count == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
